// File: hw/rtl/hotkey_chord_matcher_macros.svh
// assertion macros for the shortcut matcher checker
`ifndef HOTKEY_CHORD_MATCHER_MACROS_SVH
`define HOTKEY_CHORD_MATCHER_MACROS_SVH

// same-cycle implication, disabled in reset
`define HCM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("hcm check failed");

// next-cycle implication, disabled in reset
`define HCM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("hcm check failed");

`endif

// File: hw/rtl/hcm_pkg.sv
package hcm_pkg;

    // table sizes
    localparam int TGT_DEPTH = 16;
    localparam int SUP_DEPTH = 8;
    localparam int MAX_OUT   = 16;
    localparam int TGT_IW    = (TGT_DEPTH > 1) ? $clog2(TGT_DEPTH) : 1;
    localparam int TGT_CW    = $clog2(TGT_DEPTH + 1);
    localparam int SUP_IW    = (SUP_DEPTH > 1) ? $clog2(SUP_DEPTH) : 1;
    localparam int SUP_CW    = $clog2(SUP_DEPTH + 1);
    localparam int OUT_IW    = (MAX_OUT > 1) ? $clog2(MAX_OUT) : 1;
    localparam int OUT_CW    = $clog2(MAX_OUT + 1);

    // field widths and constants
    localparam int TS_W  = 48;
    localparam int TTL_W = 16;
    localparam logic [TTL_W-1:0] TTL_RESET    = 16'd2000;
    localparam logic [TS_W-1:0]  DL_MAX       = {TS_W{1'b1}};
    localparam logic [4:0]       CHORD_SPENT  = 5'h10;

    // configuration register indexes
    localparam logic [0:0] CFG_CAPTURE = 1'b0;
    localparam logic [0:0] CFG_TTL     = 1'b1;

    typedef enum logic [1:0] {
        OP_KEY    = 2'd0,
        OP_BIND   = 2'd1,
        OP_UNBIND = 2'd2,
        OP_ARM    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TSCAN,
        ST_SSCAN,
        ST_EMIT
    } t_state;

    // modifier bit of a key: bit0 alt, bit1 ctrl, bit2 shift, bit3 win
    function automatic logic [3:0] mod_bit(input logic [7:0] k);
        logic [3:0] b;
        b = 4'h0;
        unique case (k)
            8'hA2, 8'hA3: b = 4'h2;
            8'hA4, 8'hA5: b = 4'h1;
            8'hA0, 8'hA1: b = 4'h4;
            8'h5B, 8'h5C: b = 4'h8;
            default:      b = 4'h0;
        endcase
        return b;
    endfunction

endpackage

// File: hw/rtl/hotkey_chord_matcher.sv
// a pass-through event gives its result in the cycle after acceptance; other requests first
// run a target scan and/or a suppression scan
// one request at a time: busy until the last result, then idle before the next request;
// key events scan targets and/or suppressions, binds/unbinds targets, arms suppressions
// results cannot be stalled; each is on the ports for exactly one cycle
// synchronous active-low reset empties both tables and clears modifiers and chord
module hotkey_chord_matcher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic [1:0]  i_op,
    input  logic [7:0]  i_key_code,
    input  logic        i_key_down,
    input  logic        i_pass_through,
    input  logic [3:0]  i_async_mods,
    input  logic        i_foreground_ours,
    input  logic [47:0] i_now_ms,
    input  logic [7:0]  i_target_id,
    input  logic [3:0]  i_target_mods,
    output logic        o_result_valid,
    output logic        o_eaten,
    output logic        o_activated,
    output logic [7:0]  o_activated_id,
    output logic        o_start_menu_suppress,
    output logic        o_captured,
    output logic [3:0]  o_effective_mods,
    output logic        o_status,
    output logic        o_last
);

    hcm_pkg::t_state r_state, n_state;

    // configuration
    logic                       r_capture;
    logic [hcm_pkg::TTL_W-1:0]  r_ttl;

    // persistent state
    logic [3:0] r_held;
    logic [4:0] r_chord;
    logic [hcm_pkg::TGT_CW-1:0] r_cnt;
    logic [7:0] r_tkey  [hcm_pkg::TGT_DEPTH];
    logic [3:0] r_tmods [hcm_pkg::TGT_DEPTH];
    logic [7:0] r_tid_t [hcm_pkg::TGT_DEPTH];
    logic       r_tdown [hcm_pkg::TGT_DEPTH];
    logic       r_sv    [hcm_pkg::SUP_DEPTH];
    logic [7:0] r_skey  [hcm_pkg::SUP_DEPTH];
    logic [hcm_pkg::TS_W-1:0] r_sdl [hcm_pkg::SUP_DEPTH];

    // latched request
    hcm_pkg::t_op r_op;
    logic [7:0]  r_key;
    logic        r_down;
    logic        r_mkey;
    logic [hcm_pkg::TS_W-1:0] r_now;
    logic [hcm_pkg::TS_W-1:0] r_dl;
    logic [7:0]  r_tid;
    logic [3:0]  r_tmods_in;
    logic [3:0]  r_mods;

    // scan and result state
    logic [hcm_pkg::TGT_CW-1:0] r_tidx, r_wr;
    logic [hcm_pkg::SUP_CW-1:0] r_sidx;
    logic                       r_found;
    logic [hcm_pkg::SUP_IW-1:0] r_free_idx, r_min_idx;
    logic [hcm_pkg::TS_W-1:0]   r_min_dl;
    logic                       r_eaten, r_cap, r_status;
    logic [7:0] r_ids [hcm_pkg::MAX_OUT];
    logic       r_sms [hcm_pkg::MAX_OUT];
    logic [hcm_pkg::OUT_CW-1:0] r_n;
    logic [hcm_pkg::OUT_IW-1:0] r_k;

    // request decode
    logic        accept;
    logic [3:0]  in_bit, held_nx, mods_nx;
    logic        in_evt, in_capt;
    logic [hcm_pkg::TS_W:0] dl_sum;
    logic [hcm_pkg::TS_W-1:0] dl_sat;
    logic        t_done, s_done, is_last;
    logic [hcm_pkg::TGT_IW-1:0] ti;
    logic [hcm_pkg::SUP_IW-1:0] si;

    assign accept  = start && (r_state == hcm_pkg::ST_IDLE);
    assign in_bit  = hcm_pkg::mod_bit(i_key_code);
    assign held_nx = i_key_down ? (r_held | in_bit) : (r_held & ~in_bit);
    assign mods_nx = i_key_down ? (i_async_mods | held_nx)
                                : ((i_async_mods | held_nx) & ~in_bit);
    assign in_evt  = (i_op == hcm_pkg::OP_KEY) && !i_pass_through;
    assign in_capt = r_capture && i_foreground_ours;
    assign dl_sum  = {1'b0, i_now_ms} + (hcm_pkg::TS_W + 1)'(r_ttl);
    assign dl_sat  = dl_sum[hcm_pkg::TS_W] ? hcm_pkg::DL_MAX : dl_sum[hcm_pkg::TS_W-1:0];

    assign t_done  = (r_tidx >= r_cnt);
    assign s_done  = (r_sidx == hcm_pkg::SUP_CW'(hcm_pkg::SUP_DEPTH));
    assign ti      = r_tidx[hcm_pkg::TGT_IW-1:0];
    assign si      = r_sidx[hcm_pkg::SUP_IW-1:0];
    assign is_last = (r_n == '0) || (hcm_pkg::OUT_CW'(r_k) + 1'b1 == r_n);

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hcm_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hcm_pkg::ST_IDLE: begin
                if (start) begin
                    if (i_op == hcm_pkg::OP_BIND || i_op == hcm_pkg::OP_UNBIND) begin
                        n_state = hcm_pkg::ST_TSCAN;
                    end else if (i_op == hcm_pkg::OP_ARM) begin
                        n_state = hcm_pkg::ST_SSCAN;
                    end else if (i_pass_through) begin
                        n_state = hcm_pkg::ST_EMIT;
                    end else if (in_capt || (in_bit != 4'h0 && i_key_down)) begin
                        n_state = hcm_pkg::ST_SSCAN;
                    end else begin
                        n_state = hcm_pkg::ST_TSCAN;
                    end
                end
            end
            hcm_pkg::ST_TSCAN: begin
                if (t_done) begin
                    n_state = (r_op == hcm_pkg::OP_KEY) ? hcm_pkg::ST_SSCAN
                                                        : hcm_pkg::ST_EMIT;
                end
            end
            hcm_pkg::ST_SSCAN: begin
                if (s_done) n_state = hcm_pkg::ST_EMIT;
            end
            hcm_pkg::ST_EMIT: begin
                if (is_last) n_state = hcm_pkg::ST_IDLE;
            end
            default: n_state = hcm_pkg::ST_IDLE;
        endcase
    end

    // control state with reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capture <= 1'b0;
            r_ttl     <= hcm_pkg::TTL_RESET;
            r_held    <= 4'h0;
            r_chord   <= 5'h0;
            r_cnt     <= '0;
            for (int j = 0; j < hcm_pkg::SUP_DEPTH; j++) r_sv[j] <= 1'b0;
        end else begin
            // key event: modifiers and chord on accept
            if (accept && in_evt) begin
                r_held <= held_nx;
                if (!in_capt) begin
                    if (in_bit != 4'h0) begin
                        if (i_key_down) r_chord <= r_chord | {1'b0, mods_nx};
                    end else if (i_key_down && mods_nx != 4'h0) begin
                        r_chord <= hcm_pkg::CHORD_SPENT;
                    end
                end
            end
            // end of target scan: table count and chord release
            if (r_state == hcm_pkg::ST_TSCAN && t_done) begin
                if (r_op == hcm_pkg::OP_BIND) begin
                    if (r_wr != hcm_pkg::TGT_CW'(hcm_pkg::TGT_DEPTH)) r_cnt <= r_wr + 1'b1;
                    else r_cnt <= r_wr;
                end else if (r_op == hcm_pkg::OP_UNBIND) begin
                    r_cnt <= r_wr;
                end else if (r_mkey && !r_down) begin
                    if (r_mods == 4'h0) r_chord <= 5'h0;
                    else if (r_found) r_chord <= hcm_pkg::CHORD_SPENT;
                end
            end
            // suppression valid bits
            if (r_state == hcm_pkg::ST_SSCAN) begin
                if (!s_done) begin
                    if (r_op == hcm_pkg::OP_ARM) begin
                        if (r_sv[si] && r_skey[si] == r_key) r_sv[si] <= 1'b0;
                    end else if (r_sv[si]) begin
                        if (r_now > r_sdl[si] || r_skey[si] == r_key) r_sv[si] <= 1'b0;
                    end
                end else if (r_op == hcm_pkg::OP_ARM) begin
                    r_sv[r_found ? r_free_idx : r_min_idx] <= 1'b1;
                end
            end
            // configuration writes
            if (i_cfg_we) begin
                if (i_cfg_idx == hcm_pkg::CFG_CAPTURE) begin
                    r_capture <= i_cfg_data[0];
                    r_chord   <= 5'h0;
                end else if (i_cfg_idx == hcm_pkg::CFG_TTL) begin
                    r_ttl <= i_cfg_data;
                end
            end
        end
    end

    // datapath: request latch, scans and result buffer
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op       <= hcm_pkg::t_op'(i_op);
            r_key      <= i_key_code;
            r_down     <= i_key_down;
            r_mkey     <= (in_bit != 4'h0);
            r_now      <= i_now_ms;
            r_dl       <= dl_sat;
            r_tid      <= i_target_id;
            r_tmods_in <= i_target_mods;
            r_mods     <= in_evt ? mods_nx : 4'h0;
            r_cap      <= in_evt && in_capt;
            r_eaten    <= in_evt && in_capt;
            r_status   <= 1'b0;
            r_n        <= '0;
            r_k        <= '0;
            r_tidx     <= '0;
            r_wr       <= '0;
            r_sidx     <= '0;
            r_found    <= 1'b0;
            r_free_idx <= '0;
            r_min_idx  <= '0;
            r_min_dl   <= '0;
        end
        unique case (r_state)
            hcm_pkg::ST_TSCAN: begin
                if (!t_done) begin
                    r_tidx <= r_tidx + 1'b1;
                    if (r_op != hcm_pkg::OP_KEY) begin
                        // compact out entries with this id
                        if (r_tid_t[ti] != r_tid) begin
                            r_tkey[r_wr[hcm_pkg::TGT_IW-1:0]]  <= r_tkey[ti];
                            r_tmods[r_wr[hcm_pkg::TGT_IW-1:0]] <= r_tmods[ti];
                            r_tid_t[r_wr[hcm_pkg::TGT_IW-1:0]] <= r_tid_t[ti];
                            r_tdown[r_wr[hcm_pkg::TGT_IW-1:0]] <= r_tdown[ti];
                            r_wr <= r_wr + 1'b1;
                        end
                    end else if (r_mkey) begin
                        // modifier release: first modifier-only target equal to chord
                        if (!r_found && hcm_pkg::mod_bit(r_tkey[ti]) != 4'h0
                                && {1'b0, r_tmods[ti]} == r_chord) begin
                            r_found  <= 1'b1;
                            r_ids[0] <= r_tid_t[ti];
                            r_sms[0] <= r_chord[3];
                            r_n      <= hcm_pkg::OUT_CW'(1);
                        end
                    end else if (r_tkey[ti] == r_key) begin
                        if (!r_down) begin
                            if (r_tdown[ti]) r_eaten <= 1'b1;
                            r_tdown[ti] <= 1'b0;
                        end else if (r_tmods[ti] == r_mods) begin
                            r_eaten <= 1'b1;
                            if (!r_tdown[ti]) begin
                                r_tdown[ti] <= 1'b1;
                                if (r_n < hcm_pkg::OUT_CW'(hcm_pkg::MAX_OUT)) begin
                                    r_ids[r_n[hcm_pkg::OUT_IW-1:0]] <= r_tid_t[ti];
                                    r_sms[r_n[hcm_pkg::OUT_IW-1:0]] <= r_mods[3];
                                    r_n <= r_n + 1'b1;
                                end
                            end
                        end
                    end
                end else if (r_op == hcm_pkg::OP_BIND) begin
                    // append or refuse
                    if (r_wr == hcm_pkg::TGT_CW'(hcm_pkg::TGT_DEPTH)) begin
                        r_status <= 1'b1;
                    end else begin
                        r_tkey[r_wr[hcm_pkg::TGT_IW-1:0]]  <= r_key;
                        r_tmods[r_wr[hcm_pkg::TGT_IW-1:0]] <= r_tmods_in
                                                              | hcm_pkg::mod_bit(r_key);
                        r_tid_t[r_wr[hcm_pkg::TGT_IW-1:0]] <= r_tid;
                        r_tdown[r_wr[hcm_pkg::TGT_IW-1:0]] <= 1'b0;
                    end
                end
            end
            hcm_pkg::ST_SSCAN: begin
                if (!s_done) begin
                    r_sidx <= r_sidx + 1'b1;
                    if (r_op == hcm_pkg::OP_ARM) begin
                        // first free slot and earliest deadline
                        if ((!r_sv[si] || r_skey[si] == r_key) && !r_found) begin
                            r_found    <= 1'b1;
                            r_free_idx <= si;
                        end
                        if (r_sidx == '0 || r_sdl[si] < r_min_dl) begin
                            r_min_idx <= si;
                            r_min_dl  <= r_sdl[si];
                        end
                    end else if (r_sv[si] && !(r_now > r_sdl[si])
                                 && r_skey[si] == r_key && !r_down) begin
                        r_eaten <= 1'b1;
                    end
                end else if (r_op == hcm_pkg::OP_ARM) begin
                    r_skey[r_found ? r_free_idx : r_min_idx] <= r_key;
                    r_sdl[r_found ? r_free_idx : r_min_idx]  <= r_dl;
                end
            end
            hcm_pkg::ST_EMIT: begin
                r_k <= r_k + 1'b1;
            end
            default: begin
            end
        endcase
    end

    // result ports
    assign busy                  = (r_state != hcm_pkg::ST_IDLE);
    assign o_result_valid        = (r_state == hcm_pkg::ST_EMIT);
    assign o_eaten               = o_result_valid && r_eaten;
    assign o_activated           = o_result_valid && (r_n != '0);
    assign o_activated_id        = o_activated ? r_ids[r_k] : 8'h00;
    assign o_start_menu_suppress = o_activated && r_sms[r_k];
    assign o_captured            = o_result_valid && (r_n == '0) && r_cap;
    assign o_effective_mods      = o_result_valid ? r_mods : 4'h0;
    assign o_status              = o_result_valid && r_status;
    assign o_last                = o_result_valid && is_last;

endmodule

// File: hw/rtl/hcm_checker.sv
`include "hotkey_chord_matcher_macros.svh"

module hcm_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_result_valid,
    input logic o_activated,
    input logic o_status,
    input logic o_last
);

    // results only while a request is in progress
    `HCM_ASSERT_IMP(a_res_busy, i_clk, i_rst_n, o_result_valid, busy)
    // an accepted request keeps the block busy
    `HCM_ASSERT_NXT(a_acc_busy, i_clk, i_rst_n, start && !busy, busy)
    // the final result ends the request
    `HCM_ASSERT_NXT(a_last_end, i_clk, i_rst_n, o_result_valid && o_last, !o_result_valid)
    // refused binds never report an activation
    `HCM_ASSERT_IMP(a_stat_act, i_clk, i_rst_n, o_status, o_result_valid && !o_activated)

endmodule

bind hotkey_chord_matcher hcm_checker u_hcm_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_result_valid (o_result_valid),
    .o_activated    (o_activated),
    .o_status       (o_status),
    .o_last         (o_last)
);

// File: bench/hotkey_chord_matcher_tb.sv
`timescale 1ns / 1ps

module hotkey_chord_matcher_tb;

    localparam int NTGT = hcm_pkg::TGT_DEPTH;
    localparam int NSUP = hcm_pkg::SUP_DEPTH;
    localparam logic [47:0] TS_MAX = hcm_pkg::DL_MAX;

    typedef struct packed {
        logic       eaten;
        logic       activated;
        logic [7:0] act_id;
        logic       sms;
        logic       captured;
        logic [3:0] mods;
        logic       status;
        logic       last;
    } verdict_t;

    typedef struct packed {
        hcm_pkg::t_op op;
        logic [7:0]  key;
        logic        down;
        logic        pass;
        logic [3:0]  amods;
        logic        fg;
        logic [47:0] now;
        logic [7:0]  tid;
        logic [3:0]  tmods;
    } request_t;

    typedef struct packed {
        request_t req;
        logic     typed;
        verdict_t want;
    } stim_row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_cfg_we = 1'b0;
    logic [0:0]  i_cfg_idx = hcm_pkg::CFG_CAPTURE;
    logic [15:0] i_cfg_data = '0;
    logic [1:0]  i_op = hcm_pkg::OP_KEY;
    logic [7:0]  i_key_code = '0;
    logic        i_key_down = 1'b0;
    logic        i_pass_through = 1'b0;
    logic [3:0]  i_async_mods = '0;
    logic        i_foreground_ours = 1'b0;
    logic [47:0] i_now_ms = '0;
    logic [7:0]  i_target_id = '0;
    logic [3:0]  i_target_mods = '0;
    logic        o_result_valid;
    logic        o_eaten;
    logic        o_activated;
    logic [7:0]  o_activated_id;
    logic        o_start_menu_suppress;
    logic        o_captured;
    logic [3:0]  o_effective_mods;
    logic        o_status;
    logic        o_last;

    hotkey_chord_matcher dut (.*);

    always #4 i_clk = ~i_clk;

    // shadow state of the matcher
    logic [7:0]  tgt_key [NTGT];
    logic [3:0]  tgt_mods [NTGT];
    logic [7:0]  tgt_id [NTGT];
    logic        tgt_held [NTGT];
    int          tgt_cnt;
    logic        sup_valid [NSUP];
    logic [7:0]  sup_key [NSUP];
    logic [47:0] sup_deadline [NSUP];
    logic        mdl_capture;
    logic [15:0] mdl_ttl;
    logic [3:0]  mdl_held_mods;
    logic [4:0]  mdl_chord;

    verdict_t    pending_q[$];
    verdict_t    fresh_q[$];
    int          errors = 0;
    bit          no_idle = 0;
    logic [47:0] cur_now = 48'd1000;

    function automatic logic [3:0] modifier_of(input logic [7:0] k);
        case (k)
            8'hA0, 8'hA1: return 4'h4;
            8'hA2, 8'hA3: return 4'h2;
            8'hA4, 8'hA5: return 4'h1;
            8'h5B, 8'h5C: return 4'h8;
            default:      return 4'h0;
        endcase
    endfunction

    function automatic verdict_t plain_verdict(input logic st);
        verdict_t v;
        v = '0;
        v.status = st;
        v.last = 1'b1;
        return v;
    endfunction

    function automatic void drop_id(input logic [7:0] id);
        int w;
        w = 0;
        for (int i = 0; i < tgt_cnt; i++) begin
            if (tgt_id[i] != id) begin
                tgt_key[w] = tgt_key[i];
                tgt_mods[w] = tgt_mods[i];
                tgt_id[w] = tgt_id[i];
                tgt_held[w] = tgt_held[i];
                w++;
            end
        end
        tgt_cnt = w;
    endfunction

    // works out the results of one request into fresh_q and updates the shadow state
    function automatic void match_request(input request_t r);
        logic [3:0]  bitm;
        logic [3:0]  mods;
        logic [48:0] dl;
        logic [7:0]  ids [16];
        logic        smv [16];
        int          n;
        int          slot;
        logic        eaten;
        logic        cap;
        verdict_t    v;
        n = 0;
        eaten = 0;
        cap = 0;
        fresh_q.delete();
        case (r.op)
            hcm_pkg::OP_BIND: begin
                drop_id(r.tid);
                if (tgt_cnt >= NTGT) begin
                    fresh_q = {fresh_q, plain_verdict(1'b1)};
                end else begin
                    tgt_key[tgt_cnt] = r.key;
                    tgt_mods[tgt_cnt] = r.tmods | modifier_of(r.key);
                    tgt_id[tgt_cnt] = r.tid;
                    tgt_held[tgt_cnt] = 1'b0;
                    tgt_cnt++;
                    fresh_q = {fresh_q, plain_verdict(1'b0)};
                end
            end
            hcm_pkg::OP_UNBIND: begin
                drop_id(r.tid);
                fresh_q = {fresh_q, plain_verdict(1'b0)};
            end
            hcm_pkg::OP_ARM: begin
                dl = {1'b0, r.now} + mdl_ttl;
                if (dl > {1'b0, TS_MAX}) dl = {1'b0, TS_MAX};
                slot = -1;
                for (int i = 0; i < NSUP; i++)
                    if (sup_valid[i] && sup_key[i] == r.key) sup_valid[i] = 0;
                for (int i = 0; i < NSUP; i++)
                    if (slot < 0 && !sup_valid[i]) slot = i;
                if (slot < 0) begin
                    slot = 0;
                    for (int i = 1; i < NSUP; i++)
                        if (sup_deadline[i] < sup_deadline[slot]) slot = i;
                end
                sup_valid[slot] = 1;
                sup_key[slot] = r.key;
                sup_deadline[slot] = dl[47:0];
                fresh_q = {fresh_q, plain_verdict(1'b0)};
            end
            default: begin
                if (r.pass) begin
                    fresh_q = {fresh_q, plain_verdict(1'b0)};
                    return;
                end
                bitm = modifier_of(r.key);
                if (r.down) mdl_held_mods = mdl_held_mods | bitm;
                else mdl_held_mods = mdl_held_mods & ~bitm;
                mods = r.amods | mdl_held_mods;
                if (!r.down) mods = mods & ~bitm;
                if (mdl_capture && r.fg) begin
                    cap = 1;
                    eaten = 1;
                end else if (bitm != 0) begin
                    if (r.down) begin
                        mdl_chord = mdl_chord | {1'b0, mods};
                    end else begin
                        // modifier-only chord fires on release
                        for (int i = 0; i < tgt_cnt; i++) begin
                            if (n == 0 && modifier_of(tgt_key[i]) != 0
                                    && {1'b0, tgt_mods[i]} == mdl_chord) begin
                                ids[0] = tgt_id[i];
                                smv[0] = mdl_chord[3];
                                n = 1;
                            end
                        end
                        if (n != 0) mdl_chord = hcm_pkg::CHORD_SPENT;
                        if (mods == 0) mdl_chord = '0;
                    end
                end else begin
                    if (r.down && mods != 0) mdl_chord = hcm_pkg::CHORD_SPENT;
                    for (int i = 0; i < tgt_cnt; i++) begin
                        if (tgt_key[i] == r.key) begin
                            if (!r.down) begin
                                if (tgt_held[i]) eaten = 1;
                                tgt_held[i] = 0;
                            end else if (mods == tgt_mods[i]) begin
                                if (!tgt_held[i]) begin
                                    tgt_held[i] = 1;
                                    if (n < 16) begin
                                        ids[n] = tgt_id[i];
                                        smv[n] = mods[3];
                                        n++;
                                    end
                                end
                                eaten = 1;
                            end
                        end
                    end
                end
                // armed key-up suppressions, expired ones dropped
                for (int i = 0; i < NSUP; i++) begin
                    if (sup_valid[i]) begin
                        if (r.now > sup_deadline[i]) begin
                            sup_valid[i] = 0;
                        end else if (sup_key[i] == r.key) begin
                            if (!r.down) eaten = 1;
                            sup_valid[i] = 0;
                        end
                    end
                end
                if (n == 0) begin
                    v = '0;
                    v.eaten = eaten;
                    v.captured = cap;
                    v.mods = mods;
                    v.last = 1;
                    fresh_q = {fresh_q, v};
                end
                for (int k = 0; k < n; k++) begin
                    v = '0;
                    v.eaten = eaten;
                    v.activated = 1;
                    v.act_id = ids[k];
                    v.sms = smv[k];
                    v.mods = mods;
                    v.last = (k == n - 1);
                    fresh_q = {fresh_q, v};
                end
            end
        endcase
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (no_idle || p < 40) return 0;
        if (p < 85) return $urandom_range(1, 3);
        if (p < 97) return $urandom_range(4, 15);
        return $urandom_range(20, 60);
    endfunction

    // drive one request, wait for acceptance and queue what it should produce
    task automatic send_request(input request_t r, input logic typed, input verdict_t want);
        int gap;
        start <= 1'b1;
        i_op <= r.op;
        i_key_code <= r.key;
        i_key_down <= r.down;
        i_pass_through <= r.pass;
        i_async_mods <= r.amods;
        i_foreground_ours <= r.fg;
        i_now_ms <= r.now;
        i_target_id <= r.tid;
        i_target_mods <= r.tmods;
        do @(posedge i_clk); while (busy);
        match_request(r);
        if (typed) pending_q = {pending_q, want};
        else foreach (fresh_q[k]) pending_q = {pending_q, fresh_q[k]};
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // register write once every outstanding result has arrived
    task automatic write_reg(input logic [0:0] idx, input logic [15:0] data);
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_q.size() != 0 || busy) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == hcm_pkg::CFG_CAPTURE) begin
            mdl_capture = data[0];
            mdl_chord = '0;
        end else begin
            mdl_ttl = data;
        end
    endtask

    function automatic request_t key_req(input logic [7:0] k, input logic dn,
                                         input logic [3:0] am);
        request_t r;
        r = '0;
        r.op = hcm_pkg::OP_KEY;
        r.key = k;
        r.down = dn;
        r.amods = am;
        r.now = cur_now;
        return r;
    endfunction

    function automatic request_t rand_req();
        request_t r;
        int p;
        logic [7:0] pool [10] = '{8'h41, 8'h42, 8'h43, 8'h44, 8'hA0, 8'hA3,
                                   8'hA4, 8'hA5, 8'h5B, 8'h5C};
        p = $urandom_range(0, 99);
        r.op = (p < 55) ? hcm_pkg::OP_KEY : (p < 75) ? hcm_pkg::OP_BIND :
               (p < 85) ? hcm_pkg::OP_UNBIND : hcm_pkg::OP_ARM;
        r.key = ($urandom_range(0, 9) == 0) ? 8'($urandom) : pool[$urandom_range(0, 9)];
        r.down = 1'($urandom);
        r.pass = ($urandom_range(0, 9) == 0);
        r.amods = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'h0;
        r.fg = 1'($urandom);
        if ($urandom_range(0, 19) == 0) cur_now = {16'($urandom), 32'($urandom)};
        else cur_now = cur_now + 48'($urandom_range(0, 900));
        r.now = cur_now;
        r.tid = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 20));
        r.tmods = ($urandom_range(0, 2) == 0) ? 4'($urandom) : 4'h0;
        return r;
    endfunction

    // directed rows; typed rows carry their own expectation
    stim_row_t rows [18];

    function automatic stim_row_t mk(input request_t r, input logic typed, input verdict_t w);
        stim_row_t s;
        s.req = r;
        s.typed = typed;
        s.want = w;
        return s;
    endfunction

    function automatic request_t tbl_req(input hcm_pkg::t_op op, input logic [7:0] k,
                                         input logic [7:0] id, input logic [3:0] tm,
                                         input logic [47:0] now);
        request_t r;
        r = '0;
        r.op = op;
        r.key = k;
        r.tid = id;
        r.tmods = tm;
        r.now = now;
        return r;
    endfunction

    // result check
    always @(posedge i_clk) begin
        verdict_t got;
        verdict_t exp_v;
        if (i_rst_n && o_result_valid) begin
            got = {o_eaten, o_activated, o_activated_id, o_start_menu_suppress,
                   o_captured, o_effective_mods, o_status, o_last};
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result %p", $time, got);
                errors++;
            end else begin
                exp_v = pending_q.pop_front();
                if (got !== exp_v) begin
                    $display("%0t: mismatch expected %p actual %p", $time, exp_v, got);
                    errors++;
                end
            end
        end
    end

    initial begin
        request_t r;
        for (int i = 0; i < NTGT; i++) tgt_held[i] = 0;
        for (int i = 0; i < NSUP; i++) sup_valid[i] = 0;
        tgt_cnt = 0;
        mdl_capture = 0;
        mdl_ttl = hcm_pkg::TTL_RESET;
        mdl_held_mods = 0;
        mdl_chord = 0;

        r = '1;
        r.op = hcm_pkg::OP_KEY;
        rows[0]  = mk(r, 1, plain_verdict(0));
        rows[1]  = mk(tbl_req(hcm_pkg::OP_BIND, 8'h41, 8'd1, 4'h2, 0), 1, plain_verdict(0));
        rows[2]  = mk(tbl_req(hcm_pkg::OP_BIND, 8'hA0, 8'd2, 4'h2, 0), 1, plain_verdict(0));
        rows[3]  = mk(tbl_req(hcm_pkg::OP_BIND, 8'h5B, 8'hFF, 4'h0, 0), 1, plain_verdict(0));
        rows[4]  = mk(key_req(8'hA2, 1, 4'h0), 0, '0);
        rows[5]  = mk(key_req(8'h41, 1, 4'h0), 0, '0);
        rows[6]  = mk(key_req(8'h41, 0, 4'h0), 0, '0);
        rows[7]  = mk(key_req(8'hA2, 0, 4'h0), 0, '0);
        rows[8]  = mk(key_req(8'hA0, 1, 4'h0), 0, '0);
        rows[9]  = mk(key_req(8'hA3, 1, 4'h0), 0, '0);
        rows[10] = mk(key_req(8'hA0, 0, 4'h0), 0, '0);
        rows[11] = mk(key_req(8'hA3, 0, 4'h0), 0, '0);
        rows[12] = mk(key_req(8'h5B, 1, 4'h0), 0, '0);
        rows[13] = mk(key_req(8'h5B, 0, 4'h0), 0, '0);
        rows[14] = mk(tbl_req(hcm_pkg::OP_ARM, 8'h42, 0, 0, 48'd100), 1, plain_verdict(0));
        rows[15] = mk(tbl_req(hcm_pkg::OP_ARM, 8'hFF, 0, 0, TS_MAX), 1, plain_verdict(0));
        r = key_req(8'h42, 0, 4'hF);
        r.now = 48'd200;
        rows[16] = mk(r, 0, '0);
        rows[17] = mk(tbl_req(hcm_pkg::OP_UNBIND, 8'h00, 8'd1, 0, 0), 1, plain_verdict(0));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) send_request(rows[i].req, rows[i].typed, rows[i].want);

        // fill the target table with one key, overflow it, then press the key for a full burst
        write_reg(hcm_pkg::CFG_TTL, 16'hFFFF);
        for (int i = 0; i < NTGT; i++)
            send_request(tbl_req(hcm_pkg::OP_UNBIND, 0, 8'(i), 0, 0), 0, '0);
        send_request(tbl_req(hcm_pkg::OP_UNBIND, 0, 8'hFF, 0, 0), 0, '0);
        for (int i = 0; i < NTGT; i++)
            send_request(tbl_req(hcm_pkg::OP_BIND, 8'h50, 8'(100 + i), 4'h0, 0), 0, '0);
        send_request(tbl_req(hcm_pkg::OP_BIND, 8'h51, 8'd200, 4'h0, 0), 1, plain_verdict(1));
        send_request(key_req(8'h50, 1, 4'h0), 0, '0);
        send_request(key_req(8'h50, 0, 4'h0), 0, '0);
        for (int i = 0; i < 9; i++)
            send_request(tbl_req(hcm_pkg::OP_ARM, 8'(i), 0, 0, 48'(i * 10)), 0, '0);

        // random phases over several register settings
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    write_reg(hcm_pkg::CFG_CAPTURE, 16'h0001);
                    write_reg(hcm_pkg::CFG_TTL, 16'h0000);
                end
                1: begin
                    write_reg(hcm_pkg::CFG_CAPTURE, 16'h0000);
                    write_reg(hcm_pkg::CFG_TTL, 16'hFFFF);
                end
                2: write_reg(hcm_pkg::CFG_TTL, hcm_pkg::TTL_RESET);
                default: write_reg(hcm_pkg::CFG_TTL, 16'($urandom));
            endcase
            no_idle = (ph == 2);
            repeat (52) send_request(rand_req(), 0, '0);
        end

        start <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (errors == 0) $display("PASSED: all results match");
        else $display("FAILED: results differ");
        $finish;
    end

    // watchdog
    initial begin
        #5ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
